>>> rtl/tem_pkg.sv
// ----------------------------------------------------------------------------
// tem_pkg
// Shared types, register codes and saturation helpers for text extent measure.
// ----------------------------------------------------------------------------
package tem_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int GLYPHS = 256;

  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;

  localparam logic signed [31:0] LW_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] LW_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_GLYPH = 2'd0,
    OP_CHAR  = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_LINE_SPACING   = 2'd0,
    REG_LETTER_SPACING = 2'd1,
    REG_DEFAULT_CHAR   = 2'd2,
    REG_DEFAULT_ENABLE = 2'd3
  } reg_t;

  typedef struct packed {
    logic [1:0]          op;
    logic [7:0]          code;
    logic                entry_valid;
    logic signed [15:0]  left_bearing;
    logic signed [15:0]  glyph_width;
    logic signed [15:0]  right_bearing;
    logic [11:0]         crop_height;
  } in_item_t;

  typedef struct packed {
    logic [30:0] text_width;
    logic [23:0] text_height;
    logic        unresolved;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] left_bearing;
    logic signed [15:0] glyph_width;
    logic signed [15:0] right_bearing;
    logic [11:0]        crop_height;
  } glyph_t;

  localparam int GLYPH_W = $bits(glyph_t);

  typedef struct packed {
    logic [11:0]        line_spacing;
    logic signed [15:0] letter_spacing;
    logic [7:0]         default_char;
    logic               default_enable;
    logic               spacing_write;
    logic [11:0]        spacing_value;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    op_t                op;
    logic [7:0]         code;
    logic               resolved;
    logic signed [17:0] lead_first;
    logic signed [17:0] lead_later;
    logic signed [17:0] tail;
    logic [11:0]        crop_height;
  } lookup_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'(LW_MAX)) begin
      r = LW_MAX;
    end else if (v < 34'(LW_MIN)) begin
      r = LW_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [23:0] sat_height(input logic [23:0] a, input logic [11:0] b);
    logic [24:0] s;
    s = {1'b0, a} + 25'(b);
    return s[24] ? '1 : s[23:0];
  endfunction

endpackage

>>> rtl/tem_stream_if.sv
// ----------------------------------------------------------------------------
// tem_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface tem_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/text_extent_measure.sv
// ----------------------------------------------------------------------------
// text_extent_measure
// Pixel extent of a byte string set in a bitmap font.
// ----------------------------------------------------------------------------
// One item is taken every cycle unless the input stalls. A glyph item writes
// the 256-entry glyph table (valid flags in flops, metrics in a two-read-port
// RAM) and is seen by the very next item. A character item reads the table at
// its own code and at the default code in the cycle it is taken, then updates
// the line accumulators in the following cycle. An end-of-string item moves
// from the lookup stage register to the output register; while its result
// waits there, a second one holds in the lookup stage and input stalls.
module text_extent_measure (
  input  logic                       clk,
  input  logic                       rst,
  tem_stream_if.sink                 text,
  tem_stream_if.source               extent,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tem_pkg::ADDR_W-1:0] paddr,
  input  logic [tem_pkg::DATA_W-1:0] pwdata,
  output logic [tem_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  tem_pkg::cfg_t      cfg;
  tem_pkg::lookup_t   look;
  tem_pkg::in_item_t  item;
  tem_pkg::out_item_t result;
  logic               stall;
  logic               accept;

  assign item       = text.data;
  assign text.ready = !stall;
  assign accept     = text.valid && !stall;

  tem_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tem_lookup u_lookup (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .stall  (stall),
    .item   (item),
    .cfg    (cfg),
    .look   (look)
  );

  tem_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .look      (look),
    .cfg       (cfg),
    .out_ready (extent.ready),
    .stall     (stall),
    .out_valid (extent.valid),
    .result    (result)
  );

  assign extent.data = result;

endmodule

>>> rtl/tem_ram.sv
// ----------------------------------------------------------------------------
// tem_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module tem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> rtl/tem_cfg.sv
// ----------------------------------------------------------------------------
// tem_cfg
// APB register file: line spacing, letter spacing, default character.
// ----------------------------------------------------------------------------
module tem_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tem_pkg::ADDR_W-1:0] paddr,
  input  logic [tem_pkg::DATA_W-1:0] pwdata,
  output logic [tem_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output tem_pkg::cfg_t              cfg
);

  logic               wr;
  tem_pkg::reg_t      idx;
  logic [11:0]        line_spacing;
  logic signed [15:0] letter_spacing;
  logic [7:0]         default_char;
  logic               default_enable;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = tem_pkg::reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_spacing   <= '0;
      letter_spacing <= '0;
      default_char   <= '0;
      default_enable <= 1'b0;
    end else if (wr) begin
      case (idx)
        tem_pkg::REG_LINE_SPACING:   line_spacing   <= pwdata[11:0];
        tem_pkg::REG_LETTER_SPACING: letter_spacing <= pwdata[15:0];
        tem_pkg::REG_DEFAULT_CHAR:   default_char   <= pwdata[7:0];
        tem_pkg::REG_DEFAULT_ENABLE: default_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tem_pkg::REG_LINE_SPACING:   prdata = {20'd0, line_spacing};
      tem_pkg::REG_LETTER_SPACING: prdata = {16'd0, letter_spacing};
      tem_pkg::REG_DEFAULT_CHAR:   prdata = {24'd0, default_char};
      tem_pkg::REG_DEFAULT_ENABLE: prdata = {31'd0, default_enable};
      default:                     prdata = '0;
    endcase
  end

  assign cfg.line_spacing   = line_spacing;
  assign cfg.letter_spacing = letter_spacing;
  assign cfg.default_char   = default_char;
  assign cfg.default_enable = default_enable;
  assign cfg.spacing_write  = wr && (idx == tem_pkg::REG_LINE_SPACING);
  assign cfg.spacing_value  = pwdata[11:0];

endmodule

>>> rtl/tem_lookup.sv
// ----------------------------------------------------------------------------
// tem_lookup
// Glyph table (valid flags plus metric RAM) and the lookup stage register.
// ----------------------------------------------------------------------------
module tem_lookup (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              stall,
  input  tem_pkg::in_item_t item,
  input  tem_pkg::cfg_t     cfg,
  output tem_pkg::lookup_t  look
);

  logic [tem_pkg::GLYPHS-1:0]  present;
  logic                        s1_valid;
  tem_pkg::op_t                s1_op;
  logic [7:0]                  s1_code;
  logic                        hit_code;
  logic                        hit_default;
  logic                        glyph_we;
  tem_pkg::glyph_t             wr_glyph;
  logic [tem_pkg::GLYPH_W-1:0] rd_code;
  logic [tem_pkg::GLYPH_W-1:0] rd_default;
  tem_pkg::glyph_t             glyph;
  logic signed [17:0]          lb_x;

  assign glyph_we = accept && (tem_pkg::op_t'(item.op) == tem_pkg::OP_GLYPH);

  assign wr_glyph.left_bearing  = item.left_bearing;
  assign wr_glyph.glyph_width   = item.glyph_width;
  assign wr_glyph.right_bearing = item.right_bearing;
  assign wr_glyph.crop_height   = item.crop_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else if (glyph_we) begin
      present[item.code] <= item.entry_valid;
    end
  end

  tem_ram #(
    .WIDTH (tem_pkg::GLYPH_W),
    .DEPTH (tem_pkg::GLYPHS)
  ) u_glyph_ram (
    .clk     (clk),
    .we      (glyph_we),
    .waddr   (item.code),
    .wdata   (wr_glyph),
    .re      (accept),
    .raddr_a (item.code),
    .raddr_b (cfg.default_char),
    .rdata_a (rd_code),
    .rdata_b (rd_default)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op       <= tem_pkg::op_t'(item.op);
      s1_code     <= item.code;
      hit_code    <= present[item.code];
      hit_default <= present[cfg.default_char];
    end
  end

  assign glyph = hit_code ? tem_pkg::glyph_t'(rd_code) : tem_pkg::glyph_t'(rd_default);
  assign lb_x  = 18'(glyph.left_bearing);

  assign look.valid       = s1_valid;
  assign look.op          = s1_op;
  assign look.code        = s1_code;
  assign look.resolved    = hit_code || (cfg.default_enable && hit_default);
  assign look.lead_first  = lb_x[17] ? -lb_x : lb_x;
  assign look.lead_later  = 18'(cfg.letter_spacing) + lb_x;
  assign look.tail        = 18'(glyph.glyph_width) + 18'(glyph.right_bearing);
  assign look.crop_height = glyph.crop_height;

endmodule

>>> rtl/tem_accum.sv
// ----------------------------------------------------------------------------
// tem_accum
// Line and string accumulators with the result register.
// ----------------------------------------------------------------------------
module tem_accum (
  input  logic               clk,
  input  logic               rst,
  input  tem_pkg::lookup_t   look,
  input  tem_pkg::cfg_t      cfg,
  input  logic               out_ready,
  output logic               stall,
  output logic               out_valid,
  output tem_pkg::out_item_t result
);

  logic signed [31:0] line_width;
  logic [30:0]        widest_line;
  logic [23:0]        height_sum;
  logic [11:0]        line_height;
  logic               first_in_line;
  logic               error_seen;
  logic               any_char_seen;

  logic               fire;
  logic               take_end;
  logic               is_lf;
  logic               is_cr;
  logic signed [17:0] lead;
  logic signed [33:0] sum_ab;
  logic signed [33:0] sum_abc;
  logic signed [33:0] hi_base;
  logic signed [33:0] lo_base;
  logic signed [33:0] pick;
  logic signed [31:0] line_width_next;
  logic               line_pos;
  logic [30:0]        widest_closed;
  logic [23:0]        lf_height;
  logic [23:0]        end_height;

  assign stall    = look.valid && (look.op == tem_pkg::OP_END) && out_valid && !out_ready;
  assign fire     = look.valid && !stall;
  assign take_end = fire && (look.op == tem_pkg::OP_END);
  assign is_lf    = look.code == tem_pkg::CHAR_LF;
  assign is_cr    = look.code == tem_pkg::CHAR_CR;

  assign lead    = first_in_line ? look.lead_first : look.lead_later;
  assign sum_ab  = 34'(line_width) + 34'(lead);
  assign sum_abc = sum_ab + 34'(look.tail);
  assign hi_base = 34'(tem_pkg::LW_MAX) + 34'(look.tail);
  assign lo_base = 34'(tem_pkg::LW_MIN) + 34'(look.tail);

  always_comb begin
    if (sum_ab > 34'(tem_pkg::LW_MAX)) begin
      pick = hi_base;
    end else if (sum_ab < 34'(tem_pkg::LW_MIN)) begin
      pick = lo_base;
    end else begin
      pick = sum_abc;
    end
  end

  assign line_width_next = tem_pkg::sat32(pick);

  assign line_pos      = !line_width[31] && (line_width != 32'sd0);
  assign widest_closed = (line_pos && (line_width[30:0] > widest_line)) ?
                         line_width[30:0] : widest_line;
  assign lf_height     = tem_pkg::sat_height(height_sum, cfg.line_spacing);
  assign end_height    = tem_pkg::sat_height(height_sum, line_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width    <= '0;
      widest_line   <= '0;
      height_sum    <= '0;
      line_height   <= '0;
      first_in_line <= 1'b1;
      error_seen    <= 1'b0;
      any_char_seen <= 1'b0;
    end else if (fire) begin
      case (look.op)
        tem_pkg::OP_CHAR: begin
          any_char_seen <= 1'b1;
          if (is_lf) begin
            widest_line   <= widest_closed;
            height_sum    <= lf_height;
            line_width    <= '0;
            line_height   <= cfg.line_spacing;
            first_in_line <= 1'b1;
          end else if (!is_cr) begin
            if (!look.resolved) begin
              error_seen <= 1'b1;
            end else begin
              line_width    <= line_width_next;
              first_in_line <= 1'b0;
              if (look.crop_height > line_height) begin
                line_height <= look.crop_height;
              end
            end
          end
        end
        tem_pkg::OP_END: begin
          line_width    <= '0;
          widest_line   <= '0;
          height_sum    <= '0;
          line_height   <= cfg.line_spacing;
          first_in_line <= 1'b1;
          error_seen    <= 1'b0;
          any_char_seen <= 1'b0;
        end
        default: ;
      endcase
    end else if (cfg.spacing_write && !any_char_seen) begin
      line_height <= cfg.spacing_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_end) begin
      if (!any_char_seen) begin
        result <= '0;
      end else if (error_seen) begin
        result.text_width  <= '0;
        result.text_height <= '0;
        result.unresolved  <= 1'b1;
      end else begin
        result.text_width  <= widest_closed;
        result.text_height <= end_height;
        result.unresolved  <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_unresolved_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.unresolved |-> result.text_width == '0 && result.text_height == '0)
    else $error("unresolved result carries nonzero extent");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    take_end |=> !any_char_seen && !error_seen && line_width == 32'sd0)
    else $error("string state not cleared after end transfer");

  a_newline_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && look.op == tem_pkg::OP_CHAR && is_lf |=> first_in_line && line_width == 32'sd0)
    else $error("line state not restarted after newline");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_seen && !take_end |=> error_seen)
    else $error("error flag dropped inside a string");
`endif

endmodule
